### sv/gcls_pkg.sv
// ----------------------------------------------------------------------------
// gcls_pkg
// Shared types and constants of the grep context line selector.
// ----------------------------------------------------------------------------
package gcls_pkg;

  localparam int unsigned RING_DEPTH_DEF = 32;

  localparam int unsigned REF_W      = 32;
  localparam int unsigned LNUM_W     = 32;
  localparam int unsigned BEFORE_W   = 4;
  localparam int unsigned AFTER_W    = 5;
  localparam int unsigned TOT_W      = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BEFORE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_AFTER  = 2'd1;

  // At most this many results are produced for one input item.
  localparam int unsigned MAX_RESULTS = 15;
  localparam int unsigned RES_CNT_W   = 4;

  typedef enum logic [1:0] {
    MARK_NONE    = 2'd0,
    MARK_CONTEXT = 2'd1,
    MARK_MATCH   = 2'd2
  } mark_e;

  typedef struct packed {
    logic [LNUM_W-1:0] line_number;
    logic [REF_W-1:0]  line_ref;
    logic              is_match;
    logic              gap_before;
  } result_t;

  typedef struct packed {
    logic push;
    logic flush;
  } emit_cmd_t;

endpackage

### sv/gcls_ram.sv
// ----------------------------------------------------------------------------
// gcls_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gcls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/gcls_out.sv
// ----------------------------------------------------------------------------
// gcls_out
// Result staging: holds the newest result back until it is known whether it
// is the last one of its item, then passes it to the output register.
// ----------------------------------------------------------------------------
module gcls_out
  import gcls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  emit_cmd_t   cmd_i,
  input  result_t     res_i,
  output logic        ready_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // out_line_number, out_line_ref
  output logic [1:0]  m_axis_tuser,   // is_match, gap_before
  output logic        m_axis_tlast
);

  logic    pend_v_q, pend_v_d;
  result_t pend_q;
  logic    out_v_q, out_v_d;
  result_t out_q;
  logic    out_last_q;
  logic    out_free;
  logic    load;

  assign out_free = !out_v_q || m_axis_tready;
  assign ready_o  = !pend_v_q || out_free;

  // A held result moves on whenever a newer one arrives or the item ends.
  assign load = pend_v_q && out_free && (cmd_i.push || cmd_i.flush);

  always_comb begin
    pend_v_d = pend_v_q;
    if (cmd_i.push && ready_o) begin
      pend_v_d = 1'b1;
    end else if (cmd_i.flush && ready_o) begin
      pend_v_d = 1'b0;
    end
    if (load) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && ready_o) begin
      pend_q <= res_i;
    end
    if (load) begin
      out_q      <= pend_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.line_ref, out_q.line_number};
  assign m_axis_tuser  = {out_q.gap_before, out_q.is_match};
  assign m_axis_tlast  = out_last_q;

endmodule

### sv/grep_context_line_selector.sv
// A matching item marks its after slots and then walks its before slots (after and
// before as limited by the ring depth), one per cycle, through the single write
// port of the mark memory; the before walk pauses while the output stalls.
// Items are taken one at a time; the output register lets the next item in
// while a result still waits. Reset and every register write clear all slot
// valid bits at once, so no clearing pass follows.
// ----------------------------------------------------------------------------
// grep_context_line_selector
// Chooses the lines to list around pattern matches, with before and after
// context, keeping the recent lines in a ring of slots held in memory.
// ----------------------------------------------------------------------------
module grep_context_line_selector
  import gcls_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [REF_W-1:0]      s_axis_tdata,   // line_ref
  input  logic                  s_axis_tuser,   // matched
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [63:0]           m_axis_tdata,   // out_line_number, out_line_ref
  output logic [1:0]            m_axis_tuser,   // is_match, gap_before
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(RING_DEPTH);
  localparam int unsigned XW = (IW > TOT_W) ? IW + 1 : TOT_W + 1;
  localparam int unsigned RD_M1 = RING_DEPTH - 1;
  localparam logic [RES_CNT_W-1:0] CNT_MAX = RES_CNT_W'(MAX_RESULTS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_HEAD   = 5'b00010,
    S_AFTER  = 5'b00100,
    S_BEFORE = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [BEFORE_W-1:0] cfg_before_q, cfg_before_n;
  logic [AFTER_W-1:0]  cfg_after_q, cfg_after_n;
  logic [BEFORE_W-1:0] eb_q, eb_n;
  logic [AFTER_W-1:0]  ea_q, ea_n;
  logic [TOT_W-1:0]    total_q, total_n;
  logic [8:0]          room;
  logic                cfg_wr;

  logic [IW-1:0]        newest_q, newest_d;
  logic [LNUM_W-1:0]    nexp_q, nexp_d;
  logic [LNUM_W-1:0]    lcnt_q, lcnt_d, lcnt_inc;
  logic [IW-1:0]        walk_q, walk_d;
  logic [AFTER_W-1:0]   step_q, step_d;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic [REF_W-1:0]     ref_q;
  logic                 matched_q;
  logic [RING_DEPTH-1:0] mv_q, mv_d;
  logic [RING_DEPTH-1:0] nv_q, nv_d;
  logic [IW-1:0]        raddr_q, rd_addr;

  logic [IW-1:0]        cur1, n_clear, j_next;
  logic [XW-1:0]        n_sum;

  logic                 mk_we;
  logic [IW-1:0]        mk_waddr;
  mark_e                mk_wdata;
  logic [1:0]           mk_rdata;
  logic                 ln_we;
  logic [LNUM_W+REF_W-1:0] ln_rdata;

  mark_e                mark_eff;
  logic [LNUM_W-1:0]    num_eff;
  logic                 emit_req, want, go, out_ready;
  result_t              res;
  emit_cmd_t            cmd;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx,
                                             input logic [TOT_W-1:0] tot);
    logic [XW-1:0] s;
    s = XW'(idx) + XW'(1);
    return (s >= XW'(tot)) ? '0 : IW'(s);
  endfunction

  function automatic logic [LNUM_W-1:0] sat_inc(input logic [LNUM_W-1:0] v);
    return (v == '1) ? v : v + LNUM_W'(1);
  endfunction

  // Effective context counts from the register values after a write.
  always_comb begin
    cfg_before_n = cfg_before_q;
    cfg_after_n  = cfg_after_q;
    if (cfg_index_i == CFG_IDX_BEFORE) begin
      cfg_before_n = cfg_data_i[BEFORE_W-1:0];
    end
    if (cfg_index_i == CFG_IDX_AFTER) begin
      cfg_after_n = cfg_data_i;
    end
    eb_n    = ({5'b0, cfg_before_n} > 9'(RD_M1)) ? BEFORE_W'(RD_M1) : cfg_before_n;
    room    = 9'(RD_M1) - {5'b0, eb_n};
    ea_n    = ({4'b0, cfg_after_n} > room) ? room[AFTER_W-1:0] : cfg_after_n;
    total_n = TOT_W'(eb_n) + TOT_W'(ea_n) + TOT_W'(1);
  end

  assign cfg_ready_o   = (state_q == S_IDLE);
  assign cfg_wr        = cfg_valid_i && cfg_ready_o &&
                         ((cfg_index_i == CFG_IDX_BEFORE) || (cfg_index_i == CFG_IDX_AFTER));
  assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid_i;

  assign lcnt_inc = sat_inc(lcnt_q);
  assign cur1     = wrap_inc(newest_q, total_q);
  assign n_sum    = XW'(cur1) + XW'(ea_q);
  assign n_clear  = (n_sum >= XW'(total_q)) ? IW'(n_sum - XW'(total_q)) : IW'(n_sum);
  assign j_next   = wrap_inc(walk_q, total_q);

  assign mark_eff = mv_q[raddr_q] ? mark_e'(mk_rdata) : MARK_NONE;
  assign num_eff  = nv_q[raddr_q] ? ln_rdata[LNUM_W+REF_W-1:REF_W] : '0;

  always_comb begin
    state_d   = state_q;
    walk_d    = walk_q;
    step_d    = step_q;
    newest_d  = newest_q;
    nexp_d    = nexp_q;
    lcnt_d    = lcnt_q;
    cnt_d     = cnt_q;
    mv_d      = mv_q;
    nv_d      = nv_q;
    mk_we     = 1'b0;
    mk_waddr  = walk_q;
    mk_wdata  = MARK_CONTEXT;
    ln_we     = 1'b0;
    emit_req  = 1'b0;
    cmd.flush = 1'b0;
    res.line_number = num_eff;
    res.line_ref    = ln_rdata[REF_W-1:0];
    res.is_match    = 1'b0;
    res.gap_before  = 1'b0;

    // Results beyond the per-item limit are dropped without stalling.
    want = 1'b0;
    go   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (cfg_wr) begin
          mv_d     = '0;
          nv_d     = '0;
          nexp_d   = '0;
          lcnt_d   = '0;
          newest_d = IW'(TOT_W'(eb_n) + TOT_W'(ea_n));
        end else if (s_axis_tvalid && s_axis_tready) begin
          state_d = S_HEAD;
          cnt_d   = '0;
        end
      end
      S_HEAD: begin
        // The previous line is listed now if anything marked it.
        emit_req       = (mark_eff != MARK_NONE);
        res.is_match   = (mark_eff == MARK_MATCH);
        res.gap_before = (eb_q == '0) && (num_eff != nexp_q) && (nexp_q != '0);
        want = emit_req && (cnt_q != CNT_MAX);
        go   = !want || out_ready;
        if (go) begin
          if (emit_req) begin
            nexp_d = sat_inc(num_eff);
          end
          newest_d       = cur1;
          mv_d[n_clear]  = 1'b0;
          ln_we          = 1'b1;
          lcnt_d         = lcnt_inc;
          nv_d[cur1]     = 1'b1;
          walk_d         = cur1;
          step_d         = '0;
          if (!matched_q) begin
            state_d = S_FINISH;
          end else if (ea_q != '0) begin
            state_d = S_AFTER;
          end else if (eb_q != '0) begin
            state_d = S_BEFORE;
            walk_d  = wrap_inc(cur1, total_q);
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_AFTER: begin
        mk_we        = 1'b1;
        mk_waddr     = j_next;
        mk_wdata     = MARK_CONTEXT;
        mv_d[j_next] = 1'b1;
        walk_d       = j_next;
        step_d       = step_q + AFTER_W'(1);
        if (step_q == ea_q - AFTER_W'(1)) begin
          step_d = '0;
          if (eb_q != '0) begin
            state_d = S_BEFORE;
            walk_d  = wrap_inc(j_next, total_q);
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_BEFORE: begin
        emit_req       = (mark_eff == MARK_NONE) && nv_q[raddr_q];
        res.gap_before = (step_q == '0) && (num_eff != nexp_q) && (nexp_q != '0);
        want = emit_req && (cnt_q != CNT_MAX);
        go   = !want || out_ready;
        if (go) begin
          if (emit_req) begin
            mk_we        = 1'b1;
            mk_waddr     = walk_q;
            mk_wdata     = MARK_CONTEXT;
            mv_d[walk_q] = 1'b1;
          end
          if (step_q == {1'b0, eb_q} - AFTER_W'(1)) begin
            state_d = S_FINISH;
          end else begin
            walk_d = j_next;
            step_d = step_q + AFTER_W'(1);
          end
        end
      end
      S_FINISH: begin
        if (matched_q) begin
          mk_we          = 1'b1;
          mk_waddr       = newest_q;
          mk_wdata       = MARK_MATCH;
          mv_d[newest_q] = 1'b1;
        end
        cmd.flush = 1'b1;
        if (out_ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    cmd.push = want && go;
    if (cmd.push) begin
      cnt_d = cnt_q + RES_CNT_W'(1);
    end
  end

  assign rd_addr = (state_d == S_HEAD) ? newest_q : walk_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cfg_before_q <= '0;
      cfg_after_q  <= '0;
      eb_q         <= '0;
      ea_q         <= '0;
      total_q      <= TOT_W'(1);
      newest_q     <= '0;
      nexp_q       <= '0;
      lcnt_q       <= '0;
      walk_q       <= '0;
      step_q       <= '0;
      cnt_q        <= '0;
      mv_q         <= '0;
      nv_q         <= '0;
    end else begin
      state_q  <= state_d;
      newest_q <= newest_d;
      nexp_q   <= nexp_d;
      lcnt_q   <= lcnt_d;
      walk_q   <= walk_d;
      step_q   <= step_d;
      cnt_q    <= cnt_d;
      mv_q     <= mv_d;
      nv_q     <= nv_d;
      if (cfg_wr) begin
        cfg_before_q <= cfg_before_n;
        cfg_after_q  <= cfg_after_n;
        eb_q         <= eb_n;
        ea_q         <= ea_n;
        total_q      <= total_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= rd_addr;
    if (s_axis_tvalid && s_axis_tready) begin
      ref_q     <= s_axis_tdata;
      matched_q <= s_axis_tuser;
    end
  end

  gcls_ram #(
    .WIDTH (2),
    .DEPTH (RING_DEPTH)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mk_we),
    .waddr_i (mk_waddr),
    .wdata_i (mk_wdata),
    .raddr_i (rd_addr),
    .rdata_o (mk_rdata)
  );

  gcls_ram #(
    .WIDTH (LNUM_W + REF_W),
    .DEPTH (RING_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ln_we),
    .waddr_i (cur1),
    .wdata_i ({lcnt_inc, ref_q}),
    .raddr_i (rd_addr),
    .rdata_o (ln_rdata)
  );

  gcls_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .res_i         (res),
    .ready_o       (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grep context line selector. Text lines are fed
// on the input stream under several before/after settings, the expected
// listings are predicted line by line in a scoreboard, and each listed line on
// the output stream is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import gcls_pkg::*;

  localparam int unsigned RING      = RING_DEPTH_DEF;
  // Cycles an item may still need after its last listing has gone out.
  localparam int unsigned SETTLE    = 3 + RING + 8;
  localparam int unsigned IDLE_PCT  = 29;
  localparam int unsigned MAX32     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [LNUM_W-1:0] number;
    logic [REF_W-1:0]  text_ref;
    logic              is_match;
    logic              gap_before;
    logic              last;
  } listing_t;

  class listing_board;
    logic [LNUM_W-1:0] slot_num [RING];
    logic [REF_W-1:0]  slot_ref [RING];
    mark_e             slot_mark[RING];
    int unsigned       newest;
    logic [LNUM_W-1:0] next_exp;
    logic [LNUM_W-1:0] counter;
    int unsigned       before_cnt;
    int unsigned       after_cnt;
    listing_t          fresh[$];
    listing_t          pending[$];
    int                errors;

    function int unsigned eff_before();
      return (before_cnt > RING - 1) ? RING - 1 : before_cnt;
    endfunction

    function int unsigned eff_after();
      int unsigned room;
      room = RING - 1 - eff_before();
      return (after_cnt > room) ? room : after_cnt;
    endfunction

    function logic [LNUM_W-1:0] sat_inc(logic [LNUM_W-1:0] v);
      return (v == MAX32) ? v : v + 1;
    endfunction

    function void restart();
      for (int unsigned k = 0; k < RING; k++) begin
        slot_num[k]  = '0;
        slot_ref[k]  = '0;
        slot_mark[k] = MARK_NONE;
      end
      newest   = eff_before() + eff_after();
      next_exp = '0;
      counter  = '0;
    endfunction

    function new();
      errors     = 0;
      before_cnt = 0;
      after_cnt  = 0;
      restart();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_IDX_BEFORE) begin
        before_cnt = data[BEFORE_W-1:0];
        restart();
      end else if (idx == CFG_IDX_AFTER) begin
        after_cnt = data[AFTER_W-1:0];
        restart();
      end
    endfunction

    function void add(int unsigned slot, logic is_match, logic gap);
      listing_t l;
      if (fresh.size() >= MAX_RESULTS) return;
      l.number     = slot_num[slot];
      l.text_ref   = slot_ref[slot];
      l.is_match   = is_match;
      l.gap_before = gap;
      l.last       = 1'b0;
      fresh.push_back(l);
    endfunction

    function void note_line(logic [REF_W-1:0] text_ref, logic matched);
      int unsigned eb, ea, total, cur, n, j, i;
      logic [LNUM_W-1:0] ln;
      eb = eff_before();
      ea = eff_after();
      total = eb + ea + 1;
      fresh.delete();
      // The line marked on an earlier item is listed first.
      cur = newest % total;
      if (slot_mark[cur] != MARK_NONE) begin
        ln = slot_num[cur];
        add(cur, slot_mark[cur] == MARK_MATCH,
            (eb == 0) && (ln != next_exp) && (next_exp != 0));
        next_exp = sat_inc(ln);
      end
      cur = (cur + 1 >= total) ? 0 : cur + 1;
      newest = cur;
      n = cur + ea;
      if (n >= total) n -= total;
      slot_mark[n] = MARK_NONE;
      slot_ref[cur] = text_ref;
      counter = sat_inc(counter);
      slot_num[cur] = counter;
      if (matched) begin
        j = cur;
        for (i = 0; i < ea; i++) begin
          j = (j + 1 >= total) ? 0 : j + 1;
          slot_mark[j] = MARK_CONTEXT;
        end
        // The walk then covers the oldest slots, which hold the lines before.
        for (i = 0; i < eb; i++) begin
          j = (j + 1 >= total) ? 0 : j + 1;
          if (slot_mark[j] == MARK_NONE && slot_num[j] != 0) begin
            slot_mark[j] = MARK_CONTEXT;
            add(j, 1'b0, (i == 0) && (slot_num[j] != next_exp) && (next_exp != 0));
          end
        end
        slot_mark[cur] = MARK_MATCH;
      end
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[k]) pending.push_back(fresh[k]);
    endfunction

    function void check_listing(listing_t got);
      listing_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected listing: line %0d ref %h match %b gap %b last %b",
                 $time, got.number, got.text_ref, got.is_match, got.gap_before, got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: listing mismatch: expected line %0d ref %h match %b gap %b last %b",
                 $time, want.number, want.text_ref, want.is_match, want.gap_before,
                 want.last);
        $display("%0t:                   actual   line %0d ref %h match %b gap %b last %b",
                 $time, got.number, got.text_ref, got.is_match, got.gap_before, got.last);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [REF_W-1:0]      s_axis_tdata = '0;   // line_ref
  logic                  s_axis_tuser = 1'b0; // matched
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [63:0]           m_axis_tdata;        // out_line_number, out_line_ref
  logic [1:0]            m_axis_tuser;        // is_match, gap_before
  logic                  m_axis_tlast;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Set during one phase so that neither side idles for a long stretch.
  logic steady = 1'b0;

  listing_board board = new();

  grep_context_line_selector uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready = steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_listing({m_axis_tdata[31:0], m_axis_tdata[63:32],
                           m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast});
    end
  end

  task automatic send_line(logic [REF_W-1:0] text_ref, logic matched);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = text_ref;
    s_axis_tuser  = matched;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_line(text_ref, matched);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Waits until every predicted listing is out and the block has gone quiet.
  task automatic drain();
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] before_val,
                           logic [CFG_DATA_W-1:0] after_val,
                           int unsigned lines, int unsigned match_pct);
    drain();
    write_register(CFG_IDX_BEFORE, before_val);
    write_register(CFG_IDX_AFTER, after_val);
    repeat (lines) send_line($urandom(), $urandom_range(99) < match_pct);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // With no context every match is listed on the next item, gap-flagged unless adjacent.
    send_line(32'h0000_0000, 1'b1);
    send_line(32'hFFFF_FFFF, 1'b0);
    send_line(32'hA5A5_A5A5, 1'b1);
    send_line(32'h5A5A_5A5A, 1'b1);
    send_line(32'h1234_5678, 1'b0);
    send_line(32'h8765_4321, 1'b1);
    // Writes to indexes beyond the register list must leave the stream alone.
    drain();
    write_register(CFG_IDX_W'(2), 5'h1F);
    write_register(CFG_IDX_W'(3), 5'h00);
    send_line(32'hDEAD_BEEF, 1'b0);
    send_line(32'hCAFE_F00D, 1'b1);

    drain();
    write_register(CFG_IDX_BEFORE, 5'd2);
    write_register(CFG_IDX_AFTER, 5'd1);
    send_line(32'h0000_0001, 1'b0);
    send_line(32'h0000_0002, 1'b0);
    send_line(32'h0000_0003, 1'b0);
    send_line(32'h0000_0004, 1'b1);
    send_line(32'h0000_0005, 1'b0);
    send_line(32'h0000_0006, 1'b0);
    send_line(32'h0000_0007, 1'b0);
    send_line(32'h0000_0008, 1'b1);
    send_line(32'h0000_0009, 1'b1);
    send_line(32'h0000_000A, 1'b0);
    send_line(32'h0000_000B, 1'b0);

    // The before value is masked to four bits, and the after count is held
    // to what the ring leaves over.
    run_phase(5'h1F, 5'h1F, 40, 20);
    run_phase(5'd0, 5'd16, 25, 15);
    run_phase(5'd5, 5'd0, 25, 30);
    steady = 1'b1;
    run_phase(5'd1, 5'd1, 30, 50);
    steady = 1'b0;
    run_phase(5'd15, 5'd16, 30, 10);
    run_phase(CFG_DATA_W'($urandom_range(31)), CFG_DATA_W'($urandom_range(31)), 30, 25);
    run_phase(5'd3, 5'd7, 30, 40);

    drain();
    if (board.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
